/* sv/tbfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbfp_pkg
// Shared types and codes for the tagged BCD field parser.
// ----------------------------------------------------------------------------
package tbfp_pkg;

  localparam int unsigned AmtW   = 40;
  localparam int unsigned PosW   = 16;
  localparam int unsigned RemW   = 14;
  localparam int unsigned CauseW = 3;

  localparam logic [15:0] TagBalFlag   = 16'h3631;
  localparam logic [15:0] TagBalAmt    = 16'h3632;
  localparam logic [15:0] TagPntFlag   = 16'h3633;
  localparam logic [15:0] TagPntAmt    = 16'h3634;
  localparam logic [7:0]  FlagTrueByte = 8'h01;

  localparam logic [AmtW-1:0] AmountMax = 40'd999999999999;

  typedef enum logic [2:0] {
    PH_SIZE_HI,
    PH_SIZE_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_TAG_HI,
    PH_TAG_LO,
    PH_VALUE,
    PH_DRAIN
  } tbfp_phase_e;

  typedef enum logic [CauseW-1:0] {
    CAUSE_SIZE_REACHED = 3'd0,
    CAUSE_EMPTY_FIELD  = 3'd1,
    CAUSE_ZERO_LENGTH  = 3'd2,
    CAUSE_SHORT_LENGTH = 3'd3,
    CAUSE_UNKNOWN_TAG  = 3'd4,
    CAUSE_TRUNCATED    = 3'd5
  } tbfp_cause_e;

  // one queued byte with its last mark and its precomputed class bit
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_flag_true;
  } tbfp_item_t;

endpackage

/* sv/tagged_bcd_field_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_bcd_field_parser
// Parses a tagged BCD response field byte by byte and reports held flags,
// decoded amounts and the reason the parse ended.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   in      | input     | in_valid_i/in_ready_o  | data_byte_i, last_byte_i
//   out     | output    | out_valid_o/out_ready_i| flags, amounts, end_cause_o
//
// one byte a cycle while no waiting result stalls the parser; a byte reaches
// the parser in the cycle after acceptance and a result appears on the cycle
// after the byte that ends the parse. the two-entry input queue takes up to
// two more bytes while a waiting result stalls the parser, then in_ready_o drops
// until the result goes. reset clears the parse state and the held flags and amounts.
// ----------------------------------------------------------------------------
module tagged_bcd_field_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        balance_flag_o,
  output logic [tbfp_pkg::AmtW-1:0]   balance_amount_o,
  output logic                        point_flag_o,
  output logic [tbfp_pkg::AmtW-1:0]   point_amount_o,
  output logic [tbfp_pkg::CauseW-1:0] end_cause_o
);
  import tbfp_pkg::*;

  tbfp_item_t item;
  logic       item_valid;
  logic       item_ready;

  tbfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  tbfp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (item_valid),
    .item_ready_o     (item_ready),
    .item_i           (item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .balance_flag_o   (balance_flag_o),
    .balance_amount_o (balance_amount_o),
    .point_flag_o     (point_flag_o),
    .point_amount_o   (point_amount_o),
    .end_cause_o      (end_cause_o)
  );

endmodule

/* sv/tbfp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbfp_front
// Input side: takes bytes, tags them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tbfp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output tbfp_pkg::tbfp_item_t item_o
);
  import tbfp_pkg::*;

  tbfp_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  tbfp_item_t new_item;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];

  assign push = in_valid_i & in_ready_o;
  assign pop  = item_valid_o & item_ready_i;

  always_comb begin
    new_item.data         = data_byte_i;
    new_item.last         = last_byte_i;
    new_item.is_flag_true = (data_byte_i == FlagTrueByte);
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

/* sv/tbfp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbfp_back
// Parser: walks the field one byte a cycle unless a waiting result is not taken, and registers the result.
// ----------------------------------------------------------------------------
module tbfp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  tbfp_pkg::tbfp_item_t          item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          balance_flag_o,
  output logic [tbfp_pkg::AmtW-1:0]     balance_amount_o,
  output logic                          point_flag_o,
  output logic [tbfp_pkg::AmtW-1:0]     point_amount_o,
  output logic [tbfp_pkg::CauseW-1:0]   end_cause_o
);
  import tbfp_pkg::*;

  // bcd length with the digit string cut at the first non-digit nibble
  function automatic logic [RemW-1:0] decode_length(input logic [7:0] hi,
                                                    input logic [7:0] lo);
    logic [RemW-1:0] n0, n1, n2, n3;
    logic [RemW-1:0] v;
    n0 = RemW'(hi[7:4]);
    n1 = RemW'(hi[3:0]);
    n2 = RemW'(lo[7:4]);
    n3 = RemW'(lo[3:0]);
    if (hi[7:4] > 4'd9) begin
      v = '0;
    end else if (hi[3:0] > 4'd9) begin
      v = n0;
    end else if (lo[7:4] > 4'd9) begin
      v = RemW'(n0 * 10 + n1);
    end else if (lo[3:0] > 4'd9) begin
      v = RemW'(n0 * 100 + n1 * 10 + n2);
    end else begin
      v = RemW'(n0 * 1000 + n1 * 100 + n2 * 10 + n3);
    end
    return v;
  endfunction

  // two digits at once; clamping once at the end matches per-digit clamping
  function automatic logic [AmtW-1:0] bcd_step(input logic [AmtW-1:0] acc,
                                               input logic [7:0] b);
    logic [AmtW+6:0] wide;
    logic [AmtW+6:0] t;
    logic [AmtW+6:0] hi10;
    wide = (AmtW+7)'(acc);
    hi10 = ((AmtW+7)'(b[7:4]) << 3) + ((AmtW+7)'(b[7:4]) << 1);
    t    = (wide << 6) + (wide << 5) + (wide << 2) + hi10 + (AmtW+7)'(b[3:0]);
    if (t > (AmtW+7)'(AmountMax)) begin
      return AmountMax;
    end
    return t[AmtW-1:0];
  endfunction

  tbfp_phase_e     phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d, pos_inc;
  logic [PosW-1:0] size_q, size_d;
  logic [RemW-1:0] rem_q, rem_d, len;
  logic [15:0]     tag_q, tag_d;
  logic [AmtW-1:0] acc_q, acc_d;
  logic            bal_flag_q, bal_flag_d;
  logic [AmtW-1:0] bal_amt_q, bal_amt_d;
  logic            pnt_flag_q, pnt_flag_d;
  logic [AmtW-1:0] pnt_amt_q, pnt_amt_d;

  logic            out_valid_q;
  logic            res_bal_flag_q, res_pnt_flag_q;
  logic [AmtW-1:0] res_bal_amt_q, res_pnt_amt_q;
  tbfp_cause_e     res_cause_q;

  logic            fire;
  logic            done;
  tbfp_cause_e     cause;
  logic            finish;
  logic            known_tag;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign pos_inc      = (pos_q == '1) ? pos_q : pos_q + 1'b1;
  assign len          = decode_length(tag_q[7:0], item_i.data);
  assign known_tag    = {tag_q[15:8], item_i.data} inside
                        {TagBalFlag, TagBalAmt, TagPntFlag, TagPntAmt};

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    size_d     = size_q;
    rem_d      = rem_q;
    tag_d      = tag_q;
    acc_d      = acc_q;
    bal_flag_d = bal_flag_q;
    bal_amt_d  = bal_amt_q;
    pnt_flag_d = pnt_flag_q;
    pnt_amt_d  = pnt_amt_q;
    done       = 1'b0;
    cause      = CAUSE_SIZE_REACHED;
    finish     = 1'b0;

    if (fire) begin
      if (phase_q == PH_DRAIN) begin
        if (item_i.last) begin
          phase_d = PH_SIZE_HI;
          pos_d   = '0;
        end
      end else begin
        pos_d = pos_inc;
        case (phase_q)
          PH_SIZE_HI: begin
            size_d  = {item_i.data, 8'h00};
            phase_d = PH_SIZE_LO;
          end
          PH_SIZE_LO: begin
            size_d = {size_q[15:8], item_i.data};
            if ({size_q[15:8], item_i.data} == 16'h0000) begin
              done  = 1'b1;
              cause = CAUSE_EMPTY_FIELD;
            end else begin
              phase_d = PH_LEN_HI;
            end
          end
          PH_LEN_HI: begin
            tag_d   = {8'h00, item_i.data};
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            if (len == '0) begin
              done  = 1'b1;
              cause = CAUSE_ZERO_LENGTH;
            end else if (len == RemW'(1)) begin
              done  = 1'b1;
              cause = CAUSE_SHORT_LENGTH;
            end else begin
              rem_d   = len - RemW'(2);
              phase_d = PH_TAG_HI;
            end
          end
          PH_TAG_HI: begin
            tag_d   = {item_i.data, 8'h00};
            phase_d = PH_TAG_LO;
          end
          PH_TAG_LO: begin
            tag_d = {tag_q[15:8], item_i.data};
            if (!known_tag) begin
              done  = 1'b1;
              cause = CAUSE_UNKNOWN_TAG;
            end else begin
              acc_d = '0;
              if (rem_q == '0) begin
                finish = 1'b1;
              end else begin
                phase_d = PH_VALUE;
              end
            end
          end
          default: begin
            if (tag_q == TagBalFlag) begin
              bal_flag_d = item_i.is_flag_true;
              tag_d      = '0;
            end else if (tag_q == TagPntFlag) begin
              pnt_flag_d = item_i.is_flag_true;
              tag_d      = '0;
            end else if (tag_q == TagBalAmt || tag_q == TagPntAmt) begin
              acc_d = bcd_step(acc_q, item_i.data);
            end
            if (rem_q > RemW'(1) || rem_q == '0) begin
              rem_d = (rem_q == '0) ? rem_q : rem_q - RemW'(1);
              if (rem_q == '0) begin
                finish = 1'b1;
              end
            end else begin
              rem_d  = '0;
              finish = 1'b1;
            end
          end
        endcase

        // end of a whole block: commit amount, then check the size
        if (finish) begin
          if (tag_d == TagBalAmt) begin
            bal_amt_d = acc_d;
          end else if (tag_d == TagPntAmt) begin
            pnt_amt_d = acc_d;
          end
          if (pos_inc >= size_q) begin
            done  = 1'b1;
            cause = CAUSE_SIZE_REACHED;
          end else begin
            phase_d = PH_LEN_HI;
          end
        end

        if (!done && item_i.last) begin
          done  = 1'b1;
          cause = CAUSE_TRUNCATED;
        end

        if (done) begin
          if (item_i.last) begin
            phase_d = PH_SIZE_HI;
            pos_d   = '0;
          end else begin
            phase_d = PH_DRAIN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SIZE_HI;
      pos_q      <= '0;
      size_q     <= '0;
      rem_q      <= '0;
      tag_q      <= '0;
      acc_q      <= '0;
      bal_flag_q <= 1'b0;
      bal_amt_q  <= '0;
      pnt_flag_q <= 1'b0;
      pnt_amt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      size_q     <= size_d;
      rem_q      <= rem_d;
      tag_q      <= tag_d;
      acc_q      <= acc_d;
      bal_flag_q <= bal_flag_d;
      bal_amt_q  <= bal_amt_d;
      pnt_flag_q <= pnt_flag_d;
      pnt_amt_q  <= pnt_amt_d;
      if (fire && done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire && done) begin
      res_bal_flag_q <= bal_flag_d;
      res_bal_amt_q  <= bal_amt_d;
      res_pnt_flag_q <= pnt_flag_d;
      res_pnt_amt_q  <= pnt_amt_d;
      res_cause_q    <= cause;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign balance_flag_o   = res_bal_flag_q;
  assign balance_amount_o = res_bal_amt_q;
  assign point_flag_o     = res_pnt_flag_q;
  assign point_amount_o   = res_pnt_amt_q;
  assign end_cause_o      = res_cause_q;

endmodule

/* bench/tagged_bcd_field_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_bcd_field_parser_tb
// Drives response fields byte by byte into the parser and checks every
// result against a cycle-free predictor of the parse or a typed row. A short table of
// hand-built fields comes first, then random fields, mostly well formed, with
// broken lengths, unknown tags, bad digits, early ends and trailing bytes
// mixed in. The sender idles in bursts and the receiver stalls on its own.
// ----------------------------------------------------------------------------
module tagged_bcd_field_parser_tb;
  import tbfp_pkg::*;

  localparam int RandBytes    = 1500;
  localparam int SettleCycles = 16;
  // far above what about 1.5k bytes with idles and stalls should take
  localparam int CycleLimit   = 200000;

  typedef struct packed {
    logic            bal_flag;
    logic [AmtW-1:0] bal_amt;
    logic            pnt_flag;
    logic [AmtW-1:0] pnt_amt;
    tbfp_cause_e     cause;
  } parse_result_t;

  typedef struct packed {
    logic [7:0]    data;
    logic          is_last;
    logic          typed;
    parse_result_t want;
  } stim_row_t;

  localparam parse_result_t NoResult = '0;
  localparam int DirRows = 33;

  // hand-built fields; the expected result is typed on the byte that ends each
  localparam stim_row_t DirTable [DirRows] = '{
    // empty field right after reset
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b1, 1'b1, '{1'b0, 40'd0, 1'b0, 40'd0, CAUSE_EMPTY_FIELD}},
    // zero length
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h05, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b1, 1'b1, '{1'b0, 40'd0, 1'b0, 40'd0, CAUSE_ZERO_LENGTH}},
    // largest size, length of one
    '{8'hFF, 1'b0, 1'b0, NoResult},
    '{8'hFF, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h01, 1'b1, 1'b1, '{1'b0, 40'd0, 1'b0, 40'd0, CAUSE_SHORT_LENGTH}},
    // balance flag set, then a twelve-digit point amount of all nines
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h0F, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h03, 1'b0, 1'b0, NoResult},
    '{8'h36, 1'b0, 1'b0, NoResult},
    '{8'h31, 1'b0, 1'b0, NoResult},
    '{8'h01, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h08, 1'b0, 1'b0, NoResult},
    '{8'h36, 1'b0, 1'b0, NoResult},
    '{8'h34, 1'b0, 1'b0, NoResult},
    '{8'h99, 1'b0, 1'b0, NoResult},
    '{8'h99, 1'b0, 1'b0, NoResult},
    '{8'h99, 1'b0, 1'b0, NoResult},
    '{8'h99, 1'b0, 1'b0, NoResult},
    '{8'h99, 1'b0, 1'b0, NoResult},
    '{8'h99, 1'b1, 1'b1, '{1'b1, 40'd0, 1'b0, AmountMax, CAUSE_SIZE_REACHED}},
    // unknown tag, held values carried over
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h10, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b0, 1'b0, NoResult},
    '{8'h02, 1'b0, 1'b0, NoResult},
    '{8'hFF, 1'b0, 1'b0, NoResult},
    '{8'h00, 1'b1, 1'b1, '{1'b1, 40'd0, 1'b0, AmountMax, CAUSE_UNKNOWN_TAG}}
  };

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [7:0]        data_byte_i = '0;
  logic              last_byte_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              balance_flag_o;
  logic [AmtW-1:0]   balance_amount_o;
  logic              point_flag_o;
  logic [AmtW-1:0]   point_amount_o;
  logic [CauseW-1:0] end_cause_o;

  tagged_bcd_field_parser u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .last_byte_i,
    .out_valid_o,
    .out_ready_i,
    .balance_flag_o,
    .balance_amount_o,
    .point_flag_o,
    .point_amount_o,
    .end_cause_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predicted parser state, starts at its reset value
  tbfp_phase_e     prs_phase     = PH_SIZE_HI;
  logic [PosW-1:0] prs_pos       = '0;
  logic [15:0]     prs_size      = '0;
  logic [RemW-1:0] prs_left      = '0;
  logic [15:0]     prs_tag       = '0;
  logic [AmtW-1:0] prs_acc       = '0;
  logic            held_bal_flag = 1'b0;
  logic [AmtW-1:0] held_bal_amt  = '0;
  logic            held_pnt_flag = 1'b0;
  logic [AmtW-1:0] held_pnt_amt  = '0;

  parse_result_t pending_results [$];
  parse_result_t head_result;
  logic [8:0]    field_bytes [$];

  int mismatches    = 0;
  int results_seen  = 0;
  int bytes_sent    = 0;
  int fields_sent   = 0;
  int cycle_count   = 0;
  int burst_left    = 0;
  int stall_left    = 0;
  int rx_mode_left  = 0;
  bit rx_steady     = 1'b0;
  int cause_hits [8];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want_v);
    if (mismatches < 40) begin
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want_v);
    end
    mismatches++;
  endtask

  // four bcd digits, a nibble above nine ends the digit string
  function automatic logic [15:0] bcd_length(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] digits;
    logic [15:0] v;
    bit          stop;
    digits = {hi, lo};
    v      = '0;
    stop   = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      if (digits[i*4 +: 4] > 4'd9) stop = 1'b1;
      if (!stop) v = v * 16'd10 + 16'(digits[i*4 +: 4]);
    end
    return v;
  endfunction

  // two digits into a saturating decimal amount
  function automatic logic [AmtW-1:0] add_amount_byte(input logic [AmtW-1:0] acc,
                                                      input logic [7:0] b);
    logic [63:0] t;
    t = 64'(acc) * 64'd10 + 64'(b[7:4]);
    if (t > 64'(AmountMax)) t = 64'(AmountMax);
    t = t * 64'd10 + 64'(b[3:0]);
    if (t > 64'(AmountMax)) t = 64'(AmountMax);
    return t[AmtW-1:0];
  endfunction

  // end of a block: commit amount, then test the position against the size
  function automatic bit close_block();
    if (prs_tag == TagBalAmt) held_bal_amt = prs_acc;
    else if (prs_tag == TagPntAmt) held_pnt_amt = prs_acc;
    if (prs_pos >= prs_size) return 1'b1;
    prs_phase = PH_LEN_HI;
    return 1'b0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic is_last, output bit ended,
                            output parse_result_t r);
    logic [15:0] len;
    tbfp_cause_e cause;
    ended = 1'b0;
    r     = NoResult;
    cause = CAUSE_SIZE_REACHED;
    if (prs_phase == PH_DRAIN) begin
      if (is_last) begin
        prs_phase = PH_SIZE_HI;
        prs_pos   = '0;
      end
      return;
    end
    if (prs_pos != 16'hFFFF) prs_pos = prs_pos + 1'b1;
    case (prs_phase)
      PH_SIZE_HI: begin
        prs_size  = {b, 8'h00};
        prs_phase = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        prs_size[7:0] = b;
        if (prs_size == 16'd0) begin
          ended = 1'b1;
          cause = CAUSE_EMPTY_FIELD;
        end else begin
          prs_phase = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        prs_tag   = {8'h00, b};
        prs_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len = bcd_length(prs_tag[7:0], b);
        if (len == 16'd0) begin
          ended = 1'b1;
          cause = CAUSE_ZERO_LENGTH;
        end else if (len == 16'd1) begin
          ended = 1'b1;
          cause = CAUSE_SHORT_LENGTH;
        end else begin
          prs_left  = RemW'(len - 16'd2);
          prs_phase = PH_TAG_HI;
        end
      end
      PH_TAG_HI: begin
        prs_tag   = {b, 8'h00};
        prs_phase = PH_TAG_LO;
      end
      PH_TAG_LO: begin
        prs_tag[7:0] = b;
        if (!(prs_tag inside {TagBalFlag, TagBalAmt, TagPntFlag, TagPntAmt})) begin
          ended = 1'b1;
          cause = CAUSE_UNKNOWN_TAG;
        end else begin
          prs_acc = '0;
          if (prs_left == '0) begin
            if (close_block()) ended = 1'b1;
          end else begin
            prs_phase = PH_VALUE;
          end
        end
      end
      default: begin
        // flags look at the first value byte only
        if (prs_tag == TagBalFlag) begin
          held_bal_flag = (b == FlagTrueByte);
          prs_tag       = '0;
        end else if (prs_tag == TagPntFlag) begin
          held_pnt_flag = (b == FlagTrueByte);
          prs_tag       = '0;
        end else if (prs_tag == TagBalAmt || prs_tag == TagPntAmt) begin
          prs_acc = add_amount_byte(prs_acc, b);
        end
        if (prs_left != '0) prs_left = prs_left - 1'b1;
        if (prs_left == '0) begin
          if (close_block()) ended = 1'b1;
        end
      end
    endcase
    if (!ended && is_last) begin
      ended = 1'b1;
      cause = CAUSE_TRUNCATED;
    end
    if (!ended) return;
    if (is_last) begin
      prs_phase = PH_SIZE_HI;
      prs_pos   = '0;
    end else begin
      prs_phase = PH_DRAIN;
    end
    r = '{held_bal_flag, held_bal_amt, held_pnt_flag, held_pnt_amt, cause};
  endtask

  // hold the request until taken, then predict; a typed row replaces the prediction
  task automatic send_byte(input logic [7:0] d, input logic is_last, input logic typed,
                           input parse_result_t want);
    bit            ended;
    parse_result_t r;
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    parse_byte(d, is_last, ended, r);
    if (typed) begin
      if (!ended) report_mismatch("directed row ends no parse in predictor", 64'd0, 64'd1);
      pending_results.push_back(want);
    end else if (ended) begin
      pending_results.push_back(r);
    end
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver: steady stretches alternate with random stalls
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode_left = $urandom_range(50, 300);
      rx_steady    = ($urandom_range(0, 2) == 0);
    end else begin
      rx_mode_left--;
    end
    if (rx_steady) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 4);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 64'(end_cause_o), 64'd0);
      end else begin
        head_result = pending_results.pop_front();
        if (balance_flag_o !== head_result.bal_flag)
          report_mismatch("balance_flag", 64'(balance_flag_o), 64'(head_result.bal_flag));
        if (balance_amount_o !== head_result.bal_amt)
          report_mismatch("balance_amount", 64'(balance_amount_o),
                          64'(head_result.bal_amt));
        if (point_flag_o !== head_result.pnt_flag)
          report_mismatch("point_flag", 64'(point_flag_o), 64'(head_result.pnt_flag));
        if (point_amount_o !== head_result.pnt_amt)
          report_mismatch("point_amount", 64'(point_amount_o), 64'(head_result.pnt_amt));
        if (end_cause_o !== head_result.cause)
          report_mismatch("end_cause", 64'(end_cause_o), 64'(head_result.cause));
        cause_hits[head_result.cause]++;
        results_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int          rand_bytes;
    int          nblk;
    int          nval;
    int          lenv;
    int          pick;
    int          total;
    int          cut;
    logic [15:0] tagv;
    logic [15:0] lenbcd;
    logic [15:0] fsz;
    logic [7:0]  vb;
    rand_bytes = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      send_byte(DirTable[i].data, DirTable[i].is_last, DirTable[i].typed, DirTable[i].want);
      pace();
    end
    fields_sent += 5;
    drain_results();

    while (rand_bytes < RandBytes) begin
      field_bytes.delete();
      nblk = $urandom_range(0, 4);
      for (int k = 0; k < nblk; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          case ($urandom_range(0, 3))
            0:       tagv = TagBalFlag;
            1:       tagv = TagBalAmt;
            2:       tagv = TagPntFlag;
            default: tagv = TagPntAmt;
          endcase
          if (tagv == TagBalFlag || tagv == TagPntFlag) nval = $urandom_range(0, 2);
          else nval = $urandom_range(0, 7);
          lenv = nval + 2;
        end else begin
          tagv = 16'($urandom);
          nval = $urandom_range(0, 3);
          lenv = (pick < 86) ? $urandom_range(0, 1) : nval + 2;
        end
        lenbcd = {4'(lenv / 1000), 4'((lenv / 100) % 10), 4'((lenv / 10) % 10),
                  4'(lenv % 10)};
        if (pick >= 94) lenbcd[$urandom_range(0, 3)*4 +: 4] = 4'($urandom_range(10, 15));
        field_bytes.push_back({1'b0, lenbcd[15:8]});
        field_bytes.push_back({1'b0, lenbcd[7:0]});
        field_bytes.push_back({1'b0, tagv[15:8]});
        field_bytes.push_back({1'b0, tagv[7:0]});
        for (int v = 0; v < nval; v++) begin
          if ((tagv == TagBalFlag || tagv == TagPntFlag) && v == 0)
            vb = $urandom_range(0, 1) ? FlagTrueByte : 8'($urandom);
          else if ((tagv == TagBalAmt || tagv == TagPntAmt) && $urandom_range(0, 9) != 0)
            vb = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
          else
            vb = 8'($urandom);
          field_bytes.push_back({1'b0, vb});
        end
      end
      total = field_bytes.size() + 2;
      pick  = $urandom_range(0, 99);
      if (pick < 70) fsz = 16'(total);
      else if (pick < 78) fsz = '0;
      else if (pick < 90) fsz = 16'($urandom_range(1, total));
      else fsz = 16'($urandom);
      field_bytes.push_front({1'b0, fsz[7:0]});
      field_bytes.push_front({1'b0, fsz[15:8]});
      // trailing bytes after the parse, or a buffer cut short
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) field_bytes.push_back({1'b0, 8'($urandom)});
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, field_bytes.size());
        while (field_bytes.size() > cut) void'(field_bytes.pop_back());
      end
      rand_bytes += field_bytes.size();
      field_bytes[field_bytes.size()-1][8] = 1'b1;
      foreach (field_bytes[j]) begin
        send_byte(field_bytes[j][7:0], field_bytes[j][8], 1'b0, NoResult);
        pace();
      end
      fields_sent++;
      if ($urandom_range(0, 49) == 0) drain_results();
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);

    $display("summary: %0d bytes in %0d fields, %0d results checked, %0d mismatches",
             bytes_sent, fields_sent, results_seen, mismatches);
    $display("summary: end causes size/empty/zero/short/tag/trunc = %0d/%0d/%0d/%0d/%0d/%0d",
             cause_hits[CAUSE_SIZE_REACHED], cause_hits[CAUSE_EMPTY_FIELD],
             cause_hits[CAUSE_ZERO_LENGTH], cause_hits[CAUSE_SHORT_LENGTH],
             cause_hits[CAUSE_UNKNOWN_TAG], cause_hits[CAUSE_TRUNCATED]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/tbfp_pkg.sv
sv/tbfp_front.sv
sv/tbfp_back.sv
sv/tagged_bcd_field_parser.sv
bench/tagged_bcd_field_parser_tb.sv
